[design/upd_pkg.sv]
// upd_pkg: types, constants and the hex-pair decode function
// for the URL percent decoder. No dependencies.
package upd_pkg;

   localparam logic [7:0] PCT_CHAR = 8'h25;
   localparam int unsigned QUEUE_DEPTH = 3;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_PCT   = 2'd1,
      PH_DIGIT = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   function automatic hex_type hex_val(input logic [7:0] c);
      hex_type h;
      h.ok  = 1'b0;
      h.val = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.ok  = 1'b1;
         h.val = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.ok  = 1'b1;
         h.val = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.ok  = 1'b1;
         h.val = 4'(c - 8'h37);
      end
      return h;
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   // strtol(base 16) over two chars, wrapped to 8 bits
   function automatic logic [7:0] decode_pair(input logic [7:0] c0, input logic [7:0] c1);
      hex_type    h0;
      hex_type    h1;
      logic [7:0] v1;
      logic [7:0] res;
      h0  = hex_val(c0);
      h1  = hex_val(c1);
      v1  = {4'd0, h1.val};
      res = 8'd0;
      if (is_ws(c0) || c0 == 8'h2b) begin
         res = h1.ok ? v1 : 8'd0;
      end else if (c0 == 8'h2d) begin
         res = h1.ok ? 8'(8'd0 - v1) : 8'd0;
      end else if (h0.ok) begin
         res = h1.ok ? {h0.val, h1.val} : {4'd0, h0.val};
      end
      return res;
   endfunction

endpackage

[design/url_percent_decoder_top.sv]
// url_percent_decoder_top: streaming URL percent decoder with a three-entry
// result queue. Depends on upd_pkg.
//
// Usage:
//   Input channel req_*: one encoded byte per item, req_final_flag on the
//   last byte of a string. Result channel rsp_*: decoded bytes, rsp_out_last
//   on the last decoded byte of a string. Both are valid/ready.
//   Each accepted byte is decoded in the cycle it is accepted and its results
//   (zero, one or two) enter the registered result queue, whose head entry
//   drives rsp_*.
//   Throughput: one byte per cycle while the receiver keeps up. A final byte
//   right after '%' gives two results, so the queue port (one result out per
//   cycle) sets the sustained rate at one result per cycle.
//   A receiver stall fills the queue; req_ready drops once fewer than two
//   free entries would remain, and nothing is lost.
//   Reset (synchronous, active high) empties the queue and clears any
//   pending escape; no clearing pass is needed.
module url_percent_decoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_flag,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   upd_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]          held_ff, held_in;
   logic [1:0]          count_ff, count_in;
   upd_pkg::result_type queue_ff [upd_pkg::QUEUE_DEPTH];
   upd_pkg::result_type queue_in [upd_pkg::QUEUE_DEPTH];

   upd_pkg::result_type res0, res1;
   logic [1:0]          push_n;
   logic [1:0]          base;
   logic                pop;
   logic                req_fire;

   assign rsp_valid    = (count_ff != 2'd0);
   assign rsp_out_byte = queue_ff[0].out_byte;
   assign rsp_out_last = queue_ff[0].out_last;
   assign pop          = rsp_valid && rsp_ready;
   assign req_ready    = (count_ff <= 2'd1) || (count_ff == 2'd2 && rsp_ready);
   assign req_fire     = req_valid && req_ready;
   assign base         = count_ff - {1'b0, pop};

   // decode
   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      push_n   = 2'd0;
      res0     = '{out_byte: req_data_byte, out_last: req_final_flag};
      res1     = '{out_byte: req_data_byte, out_last: 1'b1};
      case (phase_ff)
         upd_pkg::PH_PCT: begin
            if (req_final_flag) begin
               push_n   = 2'd2;
               res0     = '{out_byte: upd_pkg::PCT_CHAR, out_last: 1'b0};
               phase_in = upd_pkg::PH_IDLE;
            end else begin
               held_in  = req_data_byte;
               phase_in = upd_pkg::PH_DIGIT;
            end
         end
         upd_pkg::PH_DIGIT: begin
            push_n   = 2'd1;
            res0     = '{out_byte: upd_pkg::decode_pair(held_ff, req_data_byte),
                         out_last: req_final_flag};
            phase_in = upd_pkg::PH_IDLE;
         end
         default: begin
            if (req_data_byte == upd_pkg::PCT_CHAR && !req_final_flag) begin
               phase_in = upd_pkg::PH_PCT;
            end else begin
               push_n   = 2'd1;
               phase_in = upd_pkg::PH_IDLE;
            end
         end
      endcase
      if (!req_fire) begin
         phase_in = phase_ff;
         held_in  = held_ff;
         push_n   = 2'd0;
      end
   end

   // result queue, head at entry 0
   always_comb begin
      for (int i = 0; i < upd_pkg::QUEUE_DEPTH; i++) begin
         if (pop && i < upd_pkg::QUEUE_DEPTH - 1) begin
            queue_in[i] = queue_ff[i + 1];
         end else begin
            queue_in[i] = queue_ff[i];
         end
         if (push_n != 2'd0 && 2'(i) == base) begin
            queue_in[i] = res0;
         end
         if (push_n == 2'd2 && 2'(i) == 2'(base + 2'd1)) begin
            queue_in[i] = res1;
         end
      end
      count_in = 2'(count_ff - {1'b0, pop} + push_n);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= upd_pkg::PH_IDLE;
         held_ff  <= 8'd0;
         count_ff <= 2'd0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (req_fire && push_n == 2'd2) |-> (base <= 2'd1))
      else $error("result queue overflow on two-result item");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == 2'($past(count_ff) - {1'b0, $past(pop)} + $past(push_n))))
      else $error("queue count mismatch");

   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_final_flag) |=> (phase_ff == upd_pkg::PH_IDLE))
      else $error("escape pending after final item");

   a_digit_from_pct: assert property (@(posedge clock) disable iff (reset)
      $rose(phase_ff == upd_pkg::PH_DIGIT) |-> ($past(phase_ff) == upd_pkg::PH_PCT))
      else $error("digit phase entered without preceding percent");
`endif

endmodule
